/* rtl/hrp_pkg.sv */
// Shared types, constants and helper functions for the HTTP response header parser.
`default_nettype none

package hrp_pkg;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_SP = 8'h20;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_0 = 8'h30;
	localparam logic [7:0] CHAR_9 = 8'h39;

	localparam logic [23:0] TERM_PREFIX = {CHAR_CR, CHAR_LF, CHAR_CR};

	localparam int NM_TE_LEN = 18;
	localparam int NM_CL_LEN = 15;
	localparam int NM_RA_LEN = 12;
	localparam int CHUNKED_LEN = 7;
	localparam int HTTP_LEN = 5;

	localparam logic [8*NM_TE_LEN-1:0] NM_TE = "transfer-encoding:";
	localparam logic [8*NM_CL_LEN-1:0] NM_CL = "content-length:";
	localparam logic [8*NM_RA_LEN-1:0] NM_RA = "retry-after:";
	localparam logic [8*CHUNKED_LEN-1:0] WORD_CHUNKED = "chunked";
	localparam logic [8*HTTP_LEN-1:0] HTTP_PREFIX = "HTTP/";

	localparam logic [7:0] STATUS_MIN_LEN = 8'd12;
	localparam logic [7:0] TE_MIN_LEN = 8'd19;
	localparam logic [7:0] CL_MIN_LEN = 8'd16;
	localparam logic [7:0] RA_MIN_LEN = 8'd13;
	localparam logic [7:0] LINE_LEN_MAX = 8'd255;

	localparam logic [31:0] MAG_CAP = 32'h8000_0000;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_CHUNK = 2'd1,
		KIND_NUM   = 2'd2
	} hrp_kind_t;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} hrp_phase_t;

	typedef struct packed {
		logic [23:0]        recent;
		logic [7:0]         line_len;
		logic               first_line;
		logic [2:0]         flags;
		hrp_kind_t          kind;
		logic [31:0]        accum;
		logic               neg;
		hrp_phase_t         phase;
		logic [2:0]         cpos;
		logic signed [15:0] status;
		logic               chunked;
		logic signed [31:0] length;
		logic signed [31:0] retry;
		logic               in_body;
	} hrp_state_t;

	localparam hrp_state_t STATE_RESET = '{
		recent:     24'h0,
		line_len:   8'h0,
		first_line: 1'b1,
		flags:      3'b111,
		kind:       KIND_NONE,
		accum:      32'h0,
		neg:        1'b0,
		phase:      PH_SKIP,
		cpos:       3'h0,
		status:     -16'sd1,
		chunked:    1'b0,
		length:     -32'sd1,
		retry:      -32'sd1,
		in_body:    1'b0
	};

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CHAR_SP) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [7:0] te_char(input logic [4:0] pos);
		if (int'(pos) >= NM_TE_LEN)
			return 8'h0;
		return NM_TE[8*(NM_TE_LEN-1-int'(pos)) +: 8];
	endfunction

	function automatic logic [7:0] cl_char(input logic [3:0] pos);
		if (int'(pos) >= NM_CL_LEN)
			return 8'h0;
		return NM_CL[8*(NM_CL_LEN-1-int'(pos)) +: 8];
	endfunction

	function automatic logic [7:0] ra_char(input logic [3:0] pos);
		if (int'(pos) >= NM_RA_LEN)
			return 8'h0;
		return NM_RA[8*(NM_RA_LEN-1-int'(pos)) +: 8];
	endfunction

	function automatic logic [7:0] chunked_char(input logic [2:0] pos);
		if (int'(pos) >= CHUNKED_LEN)
			return 8'h0;
		return WORD_CHUNKED[8*(CHUNKED_LEN-1-int'(pos)) +: 8];
	endfunction

	function automatic logic [7:0] http_char(input logic [2:0] pos);
		if (int'(pos) >= HTTP_LEN)
			return 8'h0;
		return HTTP_PREFIX[8*(HTTP_LEN-1-int'(pos)) +: 8];
	endfunction

	// atoi-style digit parser, one character per call
	function automatic hrp_state_t num_feed(input hrp_state_t s, input logic [7:0] c);
		hrp_state_t r;
		logic [35:0] t;
		logic        go;
		r = s;
		go = 1'b0;
		t = 36'h0;
		if (s.phase == PH_SKIP) begin
			if (is_ws(c)) begin
				go = 1'b0;
			end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
				r.neg = (c == CHAR_MINUS);
				r.phase = PH_DIGITS;
			end else begin
				r.phase = PH_DIGITS;
				go = 1'b1;
			end
		end else if (s.phase == PH_DIGITS) begin
			go = 1'b1;
		end
		if (go) begin
			if (c < CHAR_0 || c > CHAR_9) begin
				r.phase = PH_DONE;
			end else begin
				t = {1'b0, s.accum, 3'b000} + {3'b000, s.accum, 1'b0}
					+ {32'h0, 4'(c - CHAR_0)};
				r.accum = (t > {4'h0, MAG_CAP}) ? MAG_CAP : t[31:0];
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] sat16(input logic neg, input logic [31:0] mag);
		if (neg)
			return (mag > 32'd32768) ? 16'h8000 : 16'h0 - mag[15:0];
		return (mag > 32'd32767) ? 16'h7FFF : mag[15:0];
	endfunction

	// magnitude never exceeds 2^31, so the negated value always fits
	function automatic logic [31:0] sat32(input logic neg, input logic [31:0] mag);
		if (neg)
			return 32'h0 - mag;
		return mag[31] ? 32'h7FFF_FFFF : mag;
	endfunction

endpackage

`default_nettype wire

/* rtl/hrp_step.sv */
// Per-byte next-state logic of the header parser.
`default_nettype none

module hrp_step
	import hrp_pkg::*;
(
	input  hrp_state_t state_q,
	input  logic       new_response,
	input  logic [7:0] c,
	output hrp_state_t nxt,
	output logic       body,
	output logic       hend
);

	hrp_state_t cur;

	assign cur = new_response ? STATE_RESET : state_q;

	always_comb begin : step_blk
		logic [7:0] slen;
		logic [7:0] pos;
		hrp_phase_t ph;
		nxt = cur;
		hend = 1'b0;
		body = cur.in_body;
		slen = cur.line_len;
		pos = cur.line_len;
		ph = cur.phase;
		if (!cur.in_body) begin
			hend = (cur.recent == TERM_PREFIX) && (c == CHAR_LF);
			if (c == CHAR_LF) begin
				if (slen != 8'h0 && cur.recent[7:0] == CHAR_CR)
					slen = slen - 8'h1;
				if (cur.first_line) begin
					if (slen >= STATUS_MIN_LEN && cur.flags[0] && cur.kind == KIND_NUM)
						nxt.status = sat16(cur.neg, cur.accum);
					else
						nxt.status = -16'sd1;
					nxt.first_line = 1'b0;
				end else if (cur.kind == KIND_CHUNK) begin
					if (slen > TE_MIN_LEN && cur.cpos == 3'(CHUNKED_LEN))
						nxt.chunked = 1'b1;
				end else if (cur.kind == KIND_NUM && cur.flags[1]) begin
					if (slen > CL_MIN_LEN)
						nxt.length = sat32(cur.neg, cur.accum);
				end else if (cur.kind == KIND_NUM && cur.flags[2]) begin
					// only a positive value replaces the retry delay
					if (slen > RA_MIN_LEN && !cur.neg && cur.accum != 32'h0)
						nxt.retry = cur.accum[31] ? 32'sh7FFF_FFFF : cur.accum;
				end
				nxt.line_len = 8'h0;
				nxt.flags = 3'b111;
				nxt.kind = KIND_NONE;
				nxt.accum = 32'h0;
				nxt.neg = 1'b0;
				nxt.phase = PH_SKIP;
				nxt.cpos = 3'h0;
			end else begin
				if (cur.first_line) begin
					// flag 0 tracks the HTTP/ prefix on the status line
					if (pos < 8'(HTTP_LEN) && c != http_char(pos[2:0]))
						nxt.flags[0] = 1'b0;
					if (cur.kind == KIND_NUM)
						nxt = num_feed(nxt, c);
					else if (c == CHAR_SP)
						nxt.kind = KIND_NUM;
				end else if (cur.kind == KIND_CHUNK) begin
					if (!(cur.phase == PH_SKIP && c == CHAR_SP)) begin
						if (ph == PH_SKIP)
							ph = PH_DIGITS;
						if (ph == PH_DIGITS && cur.cpos < 3'(CHUNKED_LEN)) begin
							if (to_lower(c) == chunked_char(cur.cpos))
								nxt.cpos = cur.cpos + 3'h1;
							else
								ph = PH_DONE;
						end
						nxt.phase = ph;
					end
				end else if (cur.kind == KIND_NUM) begin
					nxt = num_feed(nxt, c);
				end else begin
					if (pos < 8'(NM_TE_LEN) && cur.flags[0]) begin
						if (to_lower(c) != te_char(pos[4:0]))
							nxt.flags[0] = 1'b0;
						else if (pos == 8'(NM_TE_LEN - 1))
							nxt.kind = KIND_CHUNK;
					end
					if (pos < 8'(NM_CL_LEN) && cur.flags[1]) begin
						if (to_lower(c) != cl_char(pos[3:0]))
							nxt.flags[1] = 1'b0;
						else if (pos == 8'(NM_CL_LEN - 1))
							nxt.kind = KIND_NUM;
					end
					if (pos < 8'(NM_RA_LEN) && cur.flags[2]) begin
						if (to_lower(c) != ra_char(pos[3:0]))
							nxt.flags[2] = 1'b0;
						else if (pos == 8'(NM_RA_LEN - 1))
							nxt.kind = KIND_NUM;
					end
				end
				if (cur.line_len < LINE_LEN_MAX)
					nxt.line_len = cur.line_len + 8'h1;
			end
			nxt.recent = {cur.recent[15:0], c};
			if (hend)
				nxt.in_body = 1'b1;
		end
	end

endmodule

`default_nettype wire

/* rtl/http_response_header_parser.sv */
// HTTP/1.1 response header parser: one response byte in per cycle unless stalled, one annotated byte out.
// Each accepted byte passes through an input register and then a result register, and a new
// byte can be taken every cycle while the output is not stalled: the whole per-byte update
// (header name compare, decimal accumulate by ten, saturation) fits between those two
// registers. new_response on a byte restarts parsing at that byte. status_code, is_chunked,
// body_length and retry_delay reflect all header lines completed so far and are final from
// the byte flagged headers_end on; every byte after the blank line is flagged is_body until
// the next new_response.
`default_nettype none

module http_response_header_parser
	import hrp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               new_response,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               is_body,
	output logic               headers_end,
	output logic signed [15:0] status_code,
	output logic               is_chunked,
	output logic signed [31:0] body_length,
	output logic signed [31:0] retry_delay
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       new_s1;
	logic       out_valid_q;
	logic       adv;
	hrp_state_t state_q;
	hrp_state_t nxt;
	logic       body;
	logic       hend;

	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
			new_s1 <= new_response;
		end
	end

	hrp_step u_step (
		.state_q      (state_q),
		.new_response (new_s1),
		.c            (byte_s1),
		.nxt          (nxt),
		.body         (body),
		.hend         (hend)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte <= byte_s1;
			is_body <= body;
			headers_end <= hend;
			status_code <= nxt.status;
			is_chunked <= nxt.chunked;
			body_length <= nxt.length;
			retry_delay <= nxt.retry;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/hrp_checker.sv */
// Port-level checker for the header parser, bound to the top level.
`default_nettype none

module hrp_checker
	import hrp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        is_body,
	input logic        headers_end
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_byte) && $stable(headers_end))
		else $error("result changed while stalled");

	// an empty result register always lets the input stage drain
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_hend_lf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && headers_end |-> out_byte == CHAR_LF && !is_body)
		else $error("headers_end on a byte that is not the terminating LF");

endmodule

bind http_response_header_parser hrp_checker u_hrp_checker (.*);

`default_nettype wire

/* bench/tb_http_response_header_parser.sv */
// Self-checking testbench for the HTTP response header parser: byte stream in, annotated bytes out.
module tb_http_response_header_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import hrp_pkg::*;

	localparam int RANDOM_ITEMS   = 800;
	localparam int QUIET_LIMIT    = 2000;
	localparam int HOLD_AT        = 250;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 10;
	localparam int STEADY_FROM    = 350;
	localparam int STEADY_TO      = 550;

	typedef struct {
		logic [7:0]         data;
		logic               body;
		logic               hend;
		logic signed [15:0] status;
		logic               chunked;
		logic signed [31:0] clen;
		logic signed [31:0] retry;
	} byte_info_t;

	// Running copy of the parser; predicts the annotation of every request byte.
	class hrp_scoreboard;
		logic [23:0]        last3;
		logic [7:0]         llen;
		bit                 first;
		logic [2:0]         hmatch;
		hrp_kind_t          vkind;
		logic [31:0]        acc;
		bit                 neg;
		hrp_phase_t         vph;
		logic [2:0]         cpos;
		logic signed [15:0] status;
		bit                 chunked;
		logic signed [31:0] clen;
		logic signed [31:0] retry;
		bit                 body;

		byte_info_t annotated_q[$];
		int errors;
		int checked;
		int hend_cnt;
		int body_cnt;

		function new();
			errors = 0;
			checked = 0;
			hend_cnt = 0;
			body_cnt = 0;
			start_over();
		endfunction

		function logic [7:0] fold(logic [7:0] c);
			return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
		endfunction

		function bit space_like(logic [7:0] c);
			return c == CHAR_SP || (c >= 8'h09 && c <= 8'h0D);
		endfunction

		function void clear_line();
			llen = 8'd0;
			hmatch = 3'b111;
			vkind = KIND_NONE;
			acc = 32'd0;
			neg = 1'b0;
			vph = PH_SKIP;
			cpos = 3'd0;
		endfunction

		function void start_over();
			last3 = 24'd0;
			first = 1'b1;
			clear_line();
			status = -16'sd1;
			chunked = 1'b0;
			clen = -32'sd1;
			retry = -32'sd1;
			body = 1'b0;
		endfunction

		function void take_digit(logic [7:0] c);
			logic [63:0] t;
			if (vph == PH_SKIP) begin
				if (space_like(c))
					return;
				if (c == CHAR_MINUS || c == CHAR_PLUS) begin
					neg = (c == CHAR_MINUS);
					vph = PH_DIGITS;
					return;
				end
				vph = PH_DIGITS;
			end
			if (vph != PH_DIGITS)
				return;
			if (c < CHAR_0 || c > CHAR_9) begin
				vph = PH_DONE;
				return;
			end
			t = {32'h0, acc} * 64'd10 + (64'(c) - 64'(CHAR_0));
			acc = (t > 64'h8000_0000) ? 32'h8000_0000 : t[31:0];
		endfunction

		function longint num_val();
			return neg ? -longint'({32'h0, acc}) : longint'({32'h0, acc});
		endfunction

		function void match_hdr(int pos, logic [7:0] c, string nm, int bitn, hrp_kind_t k);
			if (pos >= nm.len() || !hmatch[bitn])
				return;
			if (fold(c) != nm[pos]) begin
				hmatch[bitn] = 1'b0;
				return;
			end
			if (pos == nm.len() - 1)
				vkind = k;
		endfunction

		function void feed_char(logic [7:0] c);
			int pos;
			string http_word;
			string chunk_word;
			pos = llen;
			http_word = "HTTP/";
			chunk_word = "chunked";
			if (first) begin
				// on the status line bit 0 tracks the version prefix
				if (pos < 5 && c != http_word[pos])
					hmatch[0] = 1'b0;
				if (vkind == KIND_NUM)
					take_digit(c);
				else if (c == CHAR_SP)
					vkind = KIND_NUM;
			end else if (vkind == KIND_CHUNK) begin
				if (!(vph == PH_SKIP && c == CHAR_SP)) begin
					if (vph == PH_SKIP)
						vph = PH_DIGITS;
					if (vph == PH_DIGITS && cpos < 3'd7) begin
						if (fold(c) == chunk_word[cpos])
							cpos++;
						else
							vph = PH_DONE;
					end
				end
			end else if (vkind == KIND_NUM) begin
				take_digit(c);
			end else begin
				match_hdr(pos, c, "transfer-encoding:", 0, KIND_CHUNK);
				match_hdr(pos, c, "content-length:", 1, KIND_NUM);
				match_hdr(pos, c, "retry-after:", 2, KIND_NUM);
			end
			if (llen != 8'd255)
				llen++;
		endfunction

		function void close_line();
			int slen;
			longint v;
			slen = llen;
			if (slen > 0 && last3[7:0] == CHAR_CR)
				slen--;
			v = num_val();
			if (first) begin
				if (slen >= 12 && hmatch[0] && vkind == KIND_NUM) begin
					if (v < -32768)
						status = -16'sd32768;
					else if (v > 32767)
						status = 16'sd32767;
					else
						status = v[15:0];
				end else begin
					status = -16'sd1;
				end
				first = 1'b0;
			end else if (vkind == KIND_CHUNK) begin
				if (slen > 19 && cpos == 3'd7)
					chunked = 1'b1;
			end else if (vkind == KIND_NUM && hmatch[1]) begin
				if (slen > 16) begin
					if (v > 64'sd2147483647)
						clen = 32'sh7FFF_FFFF;
					else if (v < -64'sd2147483648)
						clen = 32'sh8000_0000;
					else
						clen = v[31:0];
				end
			end else if (vkind == KIND_NUM && hmatch[2]) begin
				if (slen > 13 && v > 0)
					retry = (v > 64'sd2147483647) ? 32'sh7FFF_FFFF : v[31:0];
			end
			clear_line();
		endfunction

		function byte_info_t parse_byte(logic [7:0] c, bit nr);
			byte_info_t r;
			if (nr)
				start_over();
			r.data = c;
			r.body = body;
			r.hend = 1'b0;
			if (!body) begin
				r.hend = (last3 == TERM_PREFIX) && c == CHAR_LF;
				if (c == CHAR_LF)
					close_line();
				else
					feed_char(c);
				last3 = {last3[15:0], c};
				if (r.hend)
					body = 1'b1;
			end
			r.status = status;
			r.chunked = chunked;
			r.clen = clen;
			r.retry = retry;
			return r;
		endfunction

		function void note_request(logic [7:0] c, bit nr);
			byte_info_t r;
			r = parse_byte(c, nr);
			if (r.hend)
				hend_cnt++;
			if (r.body)
				body_cnt++;
			annotated_q.push_back(r);
		endfunction

		function bit field_ok(string name, logic signed [63:0] e, logic signed [63:0] a);
			if (a !== e) begin
				$error("%s: expected %0d, actual %0d", name, e, a);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_result(byte_info_t got);
			byte_info_t e;
			bit ok;
			if (annotated_q.size() == 0) begin
				$error("out_byte: no request pending, actual %0d", got.data);
				errors++;
				return;
			end
			e = annotated_q.pop_front();
			ok = 1'b1;
			ok &= field_ok("out_byte", e.data, got.data);
			ok &= field_ok("is_body", e.body, got.body);
			ok &= field_ok("headers_end", e.hend, got.hend);
			ok &= field_ok("status_code", e.status, got.status);
			ok &= field_ok("is_chunked", e.chunked, got.chunked);
			ok &= field_ok("body_length", e.clen, got.clen);
			ok &= field_ok("retry_delay", e.retry, got.retry);
			if (!ok)
				errors++;
			checked++;
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               new_response = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         out_byte;
	logic               is_body;
	logic               headers_end;
	logic signed [15:0] status_code;
	logic               is_chunked;
	logic signed [31:0] body_length;
	logic signed [31:0] retry_delay;

	hrp_scoreboard sb;
	logic [7:0]    msg[$];
	byte_info_t    seen;
	bit            gaps_on = 1'b1;
	int            sent_cnt = 0;
	int            results_cnt = 0;
	int            responses = 0;
	int            hold_left = 0;
	bit            hold_done = 1'b0;
	int            quiet_cycles = 0;

	http_response_header_parser i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.new_response   (new_response),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.is_body        (is_body),
		.headers_end    (headers_end),
		.status_code    (status_code),
		.is_chunked     (is_chunked),
		.body_length    (body_length),
		.retry_delay    (retry_delay)
	);

	always #10 clk = ~clk;

	// ---------------- message building ----------------

	function void add_byte(logic [7:0] b);
		msg.push_back(b);
	endfunction

	function void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			msg.push_back(s[i]);
	endfunction

	function void add_line(string s);
		add_text(s);
		add_byte(CHAR_CR);
		add_byte(CHAR_LF);
	endfunction

	function void add_eol();
		if ($urandom_range(0, 99) < 85)
			add_byte(CHAR_CR);
		add_byte(CHAR_LF);
	endfunction

	function string mixcase(string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++)
			if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1))
				r[i] = r[i] - 8'd32;
		return r;
	endfunction

	function string digits(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		return s;
	endfunction

	function string opt_space();
		string s;
		s = "";
		if ($urandom_range(0, 1))
			s = " ";
		return s;
	endfunction

	function string num_text();
		case ($urandom_range(0, 15))
			0: return "";
			1: return digits(1);
			2: return $sformatf("%0d", $urandom_range(0, 999));
			3: return $sformatf("%0d", $urandom_range(0, 99999));
			4: return digits($urandom_range(10, 14));
			5: return "2147483647";
			6: return "2147483648";
			7: return "-2147483648";
			8: return {"-", digits($urandom_range(10, 13))};
			9: return {"+", digits($urandom_range(1, 4))};
			10: return {"-", digits($urandom_range(1, 5))};
			11: return {"\t ", digits(2), "x9"};
			12: return "32767";
			13: return "32768";
			14: return "-32768";
			default: return "-32769";
		endcase
	endfunction

	function void add_random_header();
		int n;
		case ($urandom_range(0, 5))
			0: begin
				add_text(mixcase("transfer-encoding:"));
				repeat ($urandom_range(0, 2))
					add_byte(CHAR_SP);
				case ($urandom_range(0, 4))
					0, 1: add_text(mixcase("chunked"));
					2: add_text("chunk");
					3: add_text("gzip, chunked");
					default: add_text(mixcase("chunkedx"));
				endcase
			end
			1: add_text({mixcase("content-length:"), opt_space(), num_text()});
			2: add_text({mixcase("retry-after:"), opt_space(), num_text()});
			3: begin
				// names that break off one letter early
				case ($urandom_range(0, 2))
					0: add_text("content-lengt:");
					1: add_text("Retry-Afte:");
					default: add_text("transfer-encodin:");
				endcase
				add_text(num_text());
			end
			4: begin
				if ($urandom_range(0, 15) == 0) begin
					// overlong line, length counter saturates
					add_text("X-Pad: ");
					repeat ($urandom_range(250, 300))
						add_byte(8'h61);
				end else begin
					add_text("Host: a");
				end
			end
			default: begin
				n = $urandom_range(0, 20);
				repeat (n)
					add_byte(8'($urandom_range(0, 254) + 1) == CHAR_LF ? CHAR_CR
						: 8'($urandom_range(0, 254) + 1));
			end
		endcase
	endfunction

	function void build_response();
		int pick;
		msg.delete();
		if ($urandom_range(0, 9) == 0) begin
			// noise, leaning on CR and LF so terminators turn up now and then
			repeat ($urandom_range(4, 30)) begin
				pick = $urandom_range(0, 5);
				add_byte(pick == 0 ? CHAR_CR : pick == 1 ? CHAR_LF : 8'($urandom_range(0, 255)));
			end
			return;
		end
		pick = $urandom_range(0, 9);
		add_text(pick == 0 ? "HTTp/" : pick == 1 ? "http/" : "HTTP/");
		add_text("1.1");
		if ($urandom_range(0, 14) == 0) begin
			add_text("-200-OK-padding");
		end else begin
			add_byte(CHAR_SP);
			add_text(num_text());
			if ($urandom_range(0, 3) != 0)
				add_text(" OK");
		end
		add_eol();
		repeat ($urandom_range(0, 4)) begin
			add_random_header();
			add_eol();
		end
		if ($urandom_range(0, 9) != 0) begin
			add_byte(CHAR_CR);
			add_byte(CHAR_LF);
		end
		repeat ($urandom_range(0, 6))
			add_byte(8'($urandom_range(0, 255)));
		// cut short now and then: the next response starts mid-stream
		if ($urandom_range(0, 19) == 0)
			while (msg.size() > 1 && $urandom_range(0, 3) != 0)
				void'(msg.pop_back());
	endfunction

	// ---------------- driving ----------------

	task automatic push_byte(input logic [7:0] b, input bit nr);
		if (gaps_on)
			while ($urandom_range(0, 99) < 35) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		rx_byte <= b;
		new_response <= nr;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(b, nr);
		sent_cnt++;
		gaps_on = !(sent_cnt >= STEADY_FROM && sent_cnt < STEADY_TO);
	endtask

	task automatic send_msg();
		responses++;
		for (int i = 0; i < msg.size(); i++)
			push_byte(msg[i], i == 0);
	endtask

	// receiver: random stall, plus one long hold-off that backs the pipe up
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.data = out_byte;
			seen.body = is_body;
			seen.hend = headers_end;
			seen.status = status_code;
			seen.chunked = is_chunked;
			seen.clen = body_length;
			seen.retry = retry_delay;
			sb.check_result(seen);
			results_cnt++;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && results_cnt >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= gaps_on && ($urandom_range(0, 99) < 35);
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no transfer for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, sb.annotated_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int base;
		sb = new();
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// chunked, saturated length, retry delay, then body bytes incl. extremes
		msg.delete();
		add_line("HTTP/1.1 200 OK");
		add_line("Transfer-Encoding:  CHUNKED");
		add_line("content-length: 99999999999");
		add_line("RETRY-AFTER: 120");
		add_line("");
		add_byte(8'hFF);
		add_byte(8'h00);
		add_byte(CHAR_CR);
		add_byte(CHAR_LF);
		send_msg();

		// negative saturation, zero and negative retry, too-short length line,
		// chunk word cut short, bare LF blank line (no terminator)
		msg.delete();
		add_line("HTTP/1.0 -99999 X");
		add_line("Content-Length: -99999999999");
		add_line("Retry-After: 0");
		add_line("Content-Length:5");
		add_line("Retry-After:-3");
		add_line("transfer-encoding: chunk");
		add_byte(CHAR_LF);
		add_byte(8'h41);
		send_msg();

		// lowercase version prefix is malformed; a short status-like line follows as a header line
		msg.delete();
		add_line("http/1.1 404 Not Found");
		add_line("HTTP/1.1 7");
		add_line("");
		send_msg();

		base = sent_cnt;
		while (sent_cnt - base < RANDOM_ITEMS) begin
			build_response();
			send_msg();
		end
		in_valid <= 1'b0;

		while (sb.annotated_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("sent %0d bytes in %0d responses, checked %0d results", sent_cnt, responses,
			sb.checked);
		$display("saw %0d header terminators and %0d body bytes; one %0d-cycle output hold-off",
			sb.hend_cnt, sb.body_cnt, HOLD_CYCLES);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
